### rtl/fractional_feedback_delay_defines.svh
// Assertion macros shared by the checker of the fractional feedback delay.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FRACTIONAL_FEEDBACK_DELAY_DEFINES_SVH
`define FRACTIONAL_FEEDBACK_DELAY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ffd_pkg.sv
// Package of the fractional feedback delay: register map, gain constants
// and the controller state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffd_pkg;

  // Configuration port address width (five 32-bit registers).
  localparam int ADDR_W = 5;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_BYPASS   = 3'd0;
  localparam logic [2:0] REG_WHOLE    = 3'd1;
  localparam logic [2:0] REG_FRACTION = 3'd2;
  localparam logic [2:0] REG_FEEDBACK = 3'd3;
  localparam logic [2:0] REG_WET      = 3'd4;

  // Unity gain in Q1.16 and the reset value of the wet share.
  localparam logic [16:0] GAIN_ONE  = 17'h10000;
  localparam logic [16:0] WET_RESET = 17'h08000;

  // Per-item sequencer states.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_TAP1   = 6'b000010,
    S_INTERP = 6'b000100,
    S_DELAY  = 6'b001000,
    S_MUL    = 6'b010000,
    S_WB     = 6'b100000
  } state_t;

endpackage

`default_nettype wire

### rtl/fractional_feedback_delay.sv
// An accepted item passes through TAP1, INTERP, DELAY, MUL and WB; write-back waits
// while a result is still held for the sink. Items are worked one at a time, owing to the
// single read port of the delay memory (two tap reads) and the registered multiply chain.
// Reset (synchronous, rst_n low) clears the pointer, the fill marker and the
// registers to their defaults; delay entries never written since reset read
// as zero through the fill marker, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module fractional_feedback_delay #(
  parameter int DEPTH       = 131072,
  parameter int SAMPLE_BITS = 24
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Input item channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [SAMPLE_BITS-1:0]       in_dry_sample,
  // Result item channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [SAMPLE_BITS-1:0]       out_mixed_sample,
  // Configuration port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [ffd_pkg::ADDR_W-1:0]   paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] DEPTH_A = AW'(DEPTH);

  // Saturate a sum to the sample range.
  function automatic logic [SB-1:0] sat_f(input logic [SB+2:0] v);
    logic [SB-1:0] res;
    if (!v[SB+2] && (v[SB+1:SB-1] != 3'b000)) begin
      res = {1'b0, {(SB-1){1'b1}}};
    end else if (v[SB+2] && (v[SB+1:SB-1] != 3'b111)) begin
      res = {1'b1, {(SB-1){1'b0}}};
    end else begin
      res = v[SB-1:0];
    end
    return res;
  endfunction

  // Configuration registers
  logic        bypass_r;
  logic [16:0] delay_whole_r;
  logic [15:0] delay_fraction_r;
  logic [16:0] feedback_gain_r;
  logic [16:0] wet_mix_r;

  // Control state
  ffd_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   wp_r;
  logic            wrap_r;
  logic            out_valid_r, out_valid_nxt;

  // Item datapath registers
  logic signed [SB-1:0]  dry_r;
  logic [AW-1:0]         r0_r;
  logic                  v0_r, v1_r, dz_r;
  logic signed [SB-1:0]  t0_r;
  logic signed [SB+17:0] iprod_r;
  logic signed [SB-1:0]  delayed_r;
  logic signed [SB+17:0] fbprod_r;
  logic signed [SB+18:0] wetprod_r;
  logic [SB-1:0]         out_mixed_r;

  // Delay memory with registered read data
  logic signed [SB-1:0] mem [DEPTH];
  logic signed [SB-1:0] rdata_r;
  logic [AW-1:0]        raddr;
  logic                 mem_re, mem_we;
  logic [SB-1:0]        stored;

  logic cfg_we;
  logic accept, wb_fire;

  // ------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r         <= 1'b0;
      delay_whole_r    <= '0;
      delay_fraction_r <= '0;
      feedback_gain_r  <= '0;
      wet_mix_r        <= ffd_pkg::WET_RESET;
    end else if (cfg_we) begin
      case (paddr[4:2])
        ffd_pkg::REG_BYPASS:   bypass_r         <= pwdata[0];
        ffd_pkg::REG_WHOLE:    delay_whole_r    <= pwdata[16:0];
        ffd_pkg::REG_FRACTION: delay_fraction_r <= pwdata[15:0];
        ffd_pkg::REG_FEEDBACK: feedback_gain_r  <= pwdata[16:0];
        ffd_pkg::REG_WET:      wet_mix_r        <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[4:2])
      ffd_pkg::REG_BYPASS:   prdata = {31'd0, bypass_r};
      ffd_pkg::REG_WHOLE:    prdata = {15'd0, delay_whole_r};
      ffd_pkg::REG_FRACTION: prdata = {16'd0, delay_fraction_r};
      ffd_pkg::REG_FEEDBACK: prdata = {15'd0, feedback_gain_r};
      ffd_pkg::REG_WET:      prdata = {15'd0, wet_mix_r};
      default:               prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------------
  // Tap address generation
  // ------------------------------------------------------------------
  logic          d_over;
  logic [AW-1:0] d_eff, r0, r1;
  logic [16:0]   fb_eff, wet_eff;

  // A delay at or beyond the memory depth acts as the longest delay.
  assign d_over = ({15'd0, delay_whole_r} >= 32'(DEPTH));
  assign d_eff  = d_over ? LAST_A : AW'(delay_whole_r);

  // Circular subtraction; the true result is below DEPTH, so AW bits hold it.
  assign r0 = wp_r - d_eff + ((wp_r < d_eff) ? DEPTH_A : '0);
  assign r1 = (r0_r == '0) ? LAST_A : (r0_r - AW'(1));

  assign fb_eff  = (feedback_gain_r > ffd_pkg::GAIN_ONE) ? ffd_pkg::GAIN_ONE
                                                          : feedback_gain_r;
  assign wet_eff = (wet_mix_r > ffd_pkg::GAIN_ONE) ? ffd_pkg::GAIN_ONE : wet_mix_r;

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  assign in_ready = (state_r == ffd_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign wb_fire  = (state_r == ffd_pkg::S_WB) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffd_pkg::S_IDLE:   if (in_valid) state_nxt = ffd_pkg::S_TAP1;
      ffd_pkg::S_TAP1:   state_nxt = ffd_pkg::S_INTERP;
      ffd_pkg::S_INTERP: state_nxt = ffd_pkg::S_DELAY;
      ffd_pkg::S_DELAY:  state_nxt = ffd_pkg::S_MUL;
      ffd_pkg::S_MUL:    state_nxt = ffd_pkg::S_WB;
      ffd_pkg::S_WB:     if (wb_fire) state_nxt = ffd_pkg::S_IDLE;
      default:           state_nxt = ffd_pkg::S_IDLE;
    endcase
  end

  // The result register is freed by the sink and loaded on write-back.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (wb_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffd_pkg::S_IDLE;
      wp_r        <= '0;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // The pointer only moves when a sample is actually stored.
      if (mem_we) begin
        if (wp_r == LAST_A) begin
          wp_r   <= '0;
          wrap_r <= 1'b1;
        end else begin
          wp_r <= wp_r + AW'(1);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Delay memory: first tap is read at accept, the older tap next cycle
  // ------------------------------------------------------------------
  assign mem_re = accept || (state_r == ffd_pkg::S_TAP1);
  assign raddr  = (state_r == ffd_pkg::S_TAP1) ? r1 : r0;
  assign mem_we = wb_fire && !bypass_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= stored;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  // ------------------------------------------------------------------
  // Arithmetic
  // ------------------------------------------------------------------
  logic signed [SB-1:0]  t1;
  logic signed [SB:0]    tap_diff;
  logic signed [SB+17:0] irnd;
  logic signed [SB:0]    wdiff;
  logic signed [SB+17:0] fbrnd;
  logic signed [SB+18:0] wrnd;
  logic signed [SB+2:0]  stored_sum, mix_sum;

  // Entries not yet written since reset read as zero.
  assign t1       = v1_r ? rdata_r : '0;
  assign tap_diff = $signed({t1[SB-1], t1}) - $signed({t0_r[SB-1], t0_r});

  // Interpolation as t0 + f*(t1 - t0), rounded half up.
  assign irnd = (iprod_r + (SB+18)'(32768)) >>> 16;

  assign wdiff = $signed({delayed_r[SB-1], delayed_r}) - $signed({dry_r[SB-1], dry_r});

  // Feedback into the line and the wet/dry blend, both rounded half up.
  assign fbrnd      = (fbprod_r + (SB+18)'(32768)) >>> 16;
  assign wrnd       = (wetprod_r + (SB+19)'(32768)) >>> 16;
  assign stored_sum = $signed({{3{dry_r[SB-1]}}, dry_r}) + fbrnd[SB+2:0];
  assign mix_sum    = $signed({{3{dry_r[SB-1]}}, dry_r}) + wrnd[SB+2:0];
  assign stored     = sat_f(stored_sum);

  always_ff @(posedge clk) begin
    if (accept) begin
      dry_r <= in_dry_sample;
      r0_r  <= r0;
      v0_r  <= wrap_r || (r0 < wp_r);
      dz_r  <= (d_eff == '0);
    end
    if (state_r == ffd_pkg::S_TAP1) begin
      t0_r <= v0_r ? rdata_r : '0;
      v1_r <= wrap_r || (r1 < wp_r);
    end
    if (state_r == ffd_pkg::S_INTERP) begin
      iprod_r <= $signed({1'b0, delay_fraction_r}) * tap_diff;
    end
    if (state_r == ffd_pkg::S_DELAY) begin
      delayed_r <= dz_r ? dry_r : (t0_r + irnd[SB-1:0]);
    end
    if (state_r == ffd_pkg::S_MUL) begin
      fbprod_r  <= $signed({1'b0, fb_eff}) * delayed_r;
      wetprod_r <= $signed({1'b0, wet_eff}) * wdiff;
    end
    if (wb_fire) begin
      out_mixed_r <= bypass_r ? dry_r : sat_f(mix_sum);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mixed_sample = out_mixed_r;

endmodule

`default_nettype wire

### rtl/ffd_checker.sv
// Port-level checker for the fractional feedback delay, bound to the top level.
// Depends on the assertion macros in fractional_feedback_delay_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "fractional_feedback_delay_defines.svh"

module ffd_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [SAMPLE_BITS-1:0] out_mixed_sample,
  input wire                   pready
);

  // The configuration port never inserts wait states.
  `FFD_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, pready, "pready dropped")

  // A result waiting for the sink holds its value.
  `FFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_mixed_sample), "stalled result changed")

  // Items are worked one at a time, so an accepted item closes the input.
  `FFD_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "input reopened right after an item")

  // A new result never appears in the cycle right after an item is taken.
  `FFD_ASSERT_NOW(a_no_instant_result, clk, rst_n, $rose(out_valid), !$past(in_valid && in_ready), "result appeared without processing time")

endmodule

bind fractional_feedback_delay ffd_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_ffd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_mixed_sample (out_mixed_sample),
  .pready           (pready)
);

`default_nettype wire

### tb/tb_fractional_feedback_delay.sv
// Self-checking testbench for the fractional feedback delay: directed and random
// sample streams under varied configurations, checked against a scoreboard predictor.
// Depends on ffd_pkg (register indexes, gain constants) and fractional_feedback_delay.
`timescale 1ns / 1ps

module tb_fractional_feedback_delay;

  localparam int          DEPTH          = 131072;
  localparam int          SAMPLE_BITS    = 24;
  localparam longint      SAMPLE_MAX     = 64'sd8388607;
  localparam longint      SAMPLE_MIN     = -64'sd8388608;
  localparam longint      UNITY          = 64'sd65536;
  localparam logic [2:0]  REG_SPARE      = 3'd7;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          RANDOM_PHASES  = 12;
  localparam int          PHASE_ITEMS    = 125;

  // Echo predictor: its own copy of the delay memory, pointer and registers.
  class echo_scoreboard;
    int               tap_mem[DEPTH];
    int unsigned      wr_ptr;
    bit               bypass;
    bit [16:0]        delay_whole;
    bit [15:0]        delay_fraction;
    bit [16:0]        feedback_gain;
    bit [16:0]        wet_mix;
    logic [23:0]      expected_mix[$];
    int               errors;

    function new();
      foreach (tap_mem[i]) tap_mem[i] = 0;
      wr_ptr         = 0;
      bypass         = 1'b0;
      delay_whole    = '0;
      delay_fraction = '0;
      feedback_gain  = '0;
      wet_mix        = ffd_pkg::WET_RESET;
      errors         = 0;
    endfunction

    function int pending();
      return expected_mix.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        ffd_pkg::REG_BYPASS:   bypass = value[0];
        ffd_pkg::REG_WHOLE:    delay_whole = value[16:0];
        ffd_pkg::REG_FRACTION: delay_fraction = value[15:0];
        ffd_pkg::REG_FEEDBACK: feedback_gain = value[16:0];
        ffd_pkg::REG_WET:      wet_mix = value[16:0];
        default: ;
      endcase
    endfunction

    // Q16 product rounding: halves go toward +infinity, then floor shift.
    function longint round_q16(longint v);
      return (v + 64'sd32768) >>> 16;
    endfunction

    function longint clip(longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
    endfunction

    // Works out the mixed sample for one accepted input item.
    function void predict_mix(logic [23:0] dry_bits);
      longint      dry;
      longint      delayed;
      longint      stored;
      longint      mixed;
      longint      frac;
      longint      fb;
      longint      wet;
      int unsigned d;
      int unsigned r0;
      int unsigned r1;
      logic [63:0] mixed_bits;

      dry = longint'($signed(dry_bits));
      if (bypass) begin
        expected_mix.push_back(dry_bits);
        return;
      end
      fb  = (feedback_gain > ffd_pkg::GAIN_ONE) ? UNITY : longint'(feedback_gain);
      wet = (wet_mix > ffd_pkg::GAIN_ONE) ? UNITY : longint'(wet_mix);
      d   = delay_whole;
      if (d >= DEPTH) d = DEPTH - 1;

      // A zero delay takes the input itself as the delayed value.
      if (d == 0) begin
        delayed = dry;
      end else begin
        r0      = (wr_ptr + DEPTH - d) % DEPTH;
        r1      = (r0 + DEPTH - 1) % DEPTH;
        frac    = longint'(delay_fraction);
        delayed = round_q16((UNITY - frac) * longint'(tap_mem[r0]) +
                            frac * longint'(tap_mem[r1]));
      end

      stored          = clip(dry + round_q16(fb * delayed));
      tap_mem[wr_ptr] = int'(stored);
      wr_ptr          = (wr_ptr + 1) % DEPTH;

      mixed      = clip(round_q16(wet * delayed + (UNITY - wet) * dry));
      mixed_bits = mixed;
      expected_mix.push_back(mixed_bits[23:0]);
    endfunction

    function void check_result(logic [23:0] got);
      logic [23:0] want;
      if (expected_mix.size() == 0) begin
        $error("mixed_sample: unexpected item, expected none, actual %0d", $signed(got));
        errors++;
        return;
      end
      want = expected_mix.pop_front();
      if (got !== want) begin
        $error("mixed_sample: expected %0d, actual %0d", $signed(want), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  wire                        in_ready;
  logic [SAMPLE_BITS-1:0]     in_dry_sample = '0;
  wire                        out_valid;
  logic                       out_ready = 1'b0;
  wire  [SAMPLE_BITS-1:0]     out_mixed_sample;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ffd_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  wire  [31:0]                prdata;
  wire                        pready;

  int                         send_idle_pct = 0;
  int                         recv_stall_pct = 0;
  int                         quiet_cycles = 0;
  echo_scoreboard             sb;

  fractional_feedback_delay #(
    .DEPTH(DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_dry_sample(in_dry_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_mixed_sample(out_mixed_sample),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, result checking and the no-progress watchdog.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) sb.check_result(out_mixed_sample);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one item, after an optional random gap, and waits for its acceptance.
  task automatic send_item(input logic [23:0] sample);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_dry_sample <= sample;
    do @(posedge clk); while (!in_ready);
    sb.predict_mix(sample);
  endtask

  // Stops offering items and waits until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register write: setup cycle, then the access cycle that commits it.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic configure(input bit byp, input bit [16:0] whole, input bit [15:0] frac,
                           input bit [16:0] fb, input bit [16:0] wet);
    reg_write(ffd_pkg::REG_BYPASS, {31'd0, byp});
    reg_write(ffd_pkg::REG_WHOLE, {15'd0, whole});
    reg_write(ffd_pkg::REG_FRACTION, {16'd0, frac});
    reg_write(ffd_pkg::REG_FEEDBACK, {15'd0, fb});
    reg_write(ffd_pkg::REG_WET, {15'd0, wet});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Gains cover zero, unity, the saturating range above unity and values between.
  function automatic bit [16:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 17'd0;
      1:       return ffd_pkg::GAIN_ONE;
      2:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Full-range samples half the time, with extremes and quiet ones mixed in.
  function automatic logic [23:0] pick_sample();
    int quiet;
    quiet = int'($urandom_range(0, 8191)) - 4096;
    case ($urandom_range(0, 7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2, 3:    return quiet[23:0];
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_phase(input int phase);
    bit        byp;
    bit [16:0] whole;
    bit [15:0] frac;
    byp = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 5))
      0:       whole = 17'd0;
      1:       whole = 17'd131071;
      2:       whole = 17'($urandom_range(0, 131071));
      default: whole = 17'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 3))
      0:       frac = 16'd0;
      1:       frac = 16'hFFFF;
      default: frac = 16'($urandom_range(0, 65535));
    endcase
    drain_results();
    configure(byp, whole, frac, pick_gain(), pick_gain());
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // Once in the run the sender holds off until the pipeline is empty.
      if (phase == 5 && i == PHASE_ITEMS / 2) drain_results();
      send_item(pick_sample());
    end
  endtask

  initial begin
    logic [23:0] extremes[5];
    extremes = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001, 24'hFFFFFF};
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: zero delay, no feedback, half wet.
    foreach (extremes[i]) send_item(extremes[i]);

    // One-sample delay with the largest weight on the older tap, unity gains.
    drain_results();
    configure(1'b0, 17'd1, 16'hFFFF, ffd_pkg::GAIN_ONE, ffd_pkg::GAIN_ONE);
    foreach (extremes[i]) send_item(extremes[i]);

    // Gains above unity saturate; dry-only output.
    drain_results();
    configure(1'b0, 17'd2, 16'd0, 17'd131071, 17'd0);
    foreach (extremes[i]) send_item(extremes[i]);

    // Longest delay: the older tap is the entry about to be overwritten.
    drain_results();
    configure(1'b0, 17'd131071, 16'h8000, ffd_pkg::GAIN_ONE, 17'd131071);
    for (int i = 0; i < 4; i++) send_item(extremes[i]);

    // A write to an unmapped register has no effect.
    drain_results();
    configure(1'b0, 17'd3, 16'd1, 17'd40000, 17'd20000);
    @(posedge clk);
    reg_write(REG_SPARE, $urandom());
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    for (int i = 0; i < 3; i++) send_item(pick_sample());

    // Bypass passes the input through and leaves the memory alone.
    drain_results();
    configure(1'b1, 17'd5, 16'h4000, ffd_pkg::GAIN_ONE, ffd_pkg::GAIN_ONE);
    send_item(24'h800000);
    send_item(24'h7FFFFF);
    send_item(pick_sample());

    for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);

    drain_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
